// ----- src/lfpmd_pkg.sv -----
// ----------------------------------------------------------------------------
// lfpmd_pkg: shared types and constants for the line-follower steering block
// Widths, reset values, register indexes, sensor weights and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package lfpmd_pkg;

  // Integral width and gain fraction bits
  localparam int SUM_WIDTH      = 16;
  localparam int GAIN_FRAC_BITS = 8;

  // Fixed field widths
  localparam int GAIN_W    = 18;
  localparam int BASE_W    = 10;
  localparam int ERR_W     = 4;
  localparam int BITS_W    = 6;
  localparam int DUTY_W    = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = GAIN_W;

  // Shared multiplier and adder widths
  localparam int MUL_A_W = GAIN_W + 1;
  localparam int MUL_B_W = SUM_WIDTH;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 2;

  // Register reset values
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = GAIN_W'(84480);
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = GAIN_W'(13);
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = GAIN_W'(0);
  localparam logic [BASE_W-1:0] BASE_SPEED_RST = BASE_W'(430);

  // Speed limits
  localparam int SPEED_MAX   = 999;
  localparam int SPEED_LIMIT = 950;

  // Sensor weights in halves, far left to far right
  localparam logic signed [4:0] HALF_WEIGHT [BITS_W] = '{
    -5'sd8, -5'sd5, -5'sd3, 5'sd3, 5'sd5, 5'sd8
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 2'd0,
    REG_INTEG_GAIN = 2'd1,
    REG_DERIV_GAIN = 2'd2,
    REG_BASE_SPEED = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_INTEG,
    S_MUL_I,
    S_MUL_D,
    S_ACC_D,
    S_SPD_L,
    S_RND_L,
    S_SPD_R,
    S_RND_R,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

// ----- src/line_follow_pid_motor_drive.sv -----
// ----------------------------------------------------------------------------
// line_follow_pid_motor_drive: line-sensor centroid, PID and motor drive split
// One sensor beat in, one steering beat out, computed on a shared datapath.
// ----------------------------------------------------------------------------
`default_nettype none

// Each input beat carries six line-sensor bits. The block weights them
// (-4, -2.5, -1.5, +1.5, +2.5, +4 from far left to far right), truncates the
// sum toward zero, divides it by the number of active sensors (again toward
// zero; no sensor gives error 0), updates a saturating 16-bit integral and
// forms a PID correction with Q8 gains. Left speed is base plus correction,
// right speed is base minus it; each is limited (above 999 becomes 950, below
// -950 becomes -950) and split into a direction bit and a duty magnitude.
// One beat is accepted at a time; the next is taken only once the previous
// one has left the sequencer, and the divide runs longer for a larger quotient (0 to 4).
// The quotient comes from a repeated-subtraction divide, and every add,
// subtract, saturate and rounding step goes through one shared adder, with the
// three gain products through one shared multiplier. The result sits in an
// output register, so the next beat is accepted while it waits; only a
// second finished result stalls behind an unaccepted one.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// must only be changed while no beat is in flight.

module line_follow_pid_motor_drive
  import lfpmd_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  // sensor channel
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire  [BITS_W-1:0]      in_line_bits,
  // steering channel
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic signed [ERR_W-1:0] out_line_error,
  output logic                   out_left_forward,
  output logic [DUTY_W-1:0]      out_left_duty,
  output logic                   out_right_forward,
  output logic [DUTY_W-1:0]      out_right_duty,
  // configuration write port
  input  wire                    cfg_we,
  input  wire  [CFG_IDX_W-1:0]   cfg_index,
  input  wire  [CFG_W-1:0]       cfg_data
);

  // Integral saturation bounds, sign-extended to the adder width
  localparam logic signed [ACC_W-1:0] SUM_HI =
    {{(ACC_W-SUM_WIDTH+1){1'b0}}, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SUM_LO = ~SUM_HI;
  // Added to negative values before the shift so the shift truncates toward zero
  localparam logic signed [ACC_W-1:0] ROUND_BIAS =
    {{(ACC_W-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}};
  localparam logic signed [ACC_W-1:0] SPD_MAX = ACC_W'(SPEED_MAX);
  localparam logic signed [ACC_W-1:0] SPD_POS = ACC_W'(SPEED_LIMIT);
  localparam logic signed [ACC_W-1:0] SPD_NEG = ACC_W'(-SPEED_LIMIT);

  // Limit a speed and split it into {forward, duty}
  function automatic logic [DUTY_W:0] drive_split(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] lim;
    logic        [ACC_W-1:0] mag;
    begin
      lim = v;
      if (v > SPD_MAX) begin
        lim = SPD_POS;
      end else if (v < SPD_NEG) begin
        lim = SPD_NEG;
      end
      mag = lim[ACC_W-1] ? (~lim + ACC_W'(1)) : lim;
      return {(lim > 0), mag[DUTY_W-1:0]};
    end
  endfunction

  // Control state
  state_t                    state_r, state_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [SUM_WIDTH-1:0] error_sum_r, error_sum_nxt;
  logic signed [ERR_W-1:0]   prior_r, prior_nxt;

  // Configuration
  logic [GAIN_W-1:0]         prop_r, integ_r, deriv_r;
  logic [BASE_W-1:0]         base_r;

  // Working payload
  logic [3:0]                mag_r, mag_nxt;
  logic [2:0]                cnt_r, cnt_nxt;
  logic                      neg_r, neg_nxt;
  logic [2:0]                quo_r, quo_nxt;
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [ACC_W-1:0]   spd_r, spd_nxt;
  logic                      left_fwd_r, left_fwd_nxt;
  logic [DUTY_W-1:0]         left_duty_r, left_duty_nxt;
  logic                      right_fwd_r, right_fwd_nxt;
  logic [DUTY_W-1:0]         right_duty_r, right_duty_nxt;

  // Output registers
  logic signed [ERR_W-1:0]   out_err_r, out_err_nxt;
  logic                      out_lfwd_r, out_lfwd_nxt;
  logic [DUTY_W-1:0]         out_lduty_r, out_lduty_nxt;
  logic                      out_rfwd_r, out_rfwd_nxt;
  logic [DUTY_W-1:0]         out_rduty_r, out_rduty_nxt;

  // Sensor front end
  logic signed [5:0]         sum2;
  logic [2:0]                cnt;
  logic [5:0]                sum2_abs;

  // Shared adder
  logic                      add_sub;
  logic signed [ACC_W-1:0]   add_a, add_b, add_y;

  // Shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_y;

  logic signed [4:0]         delta;
  logic signed [ACC_W-1:0]   base_sh;
  logic signed [ACC_W-1:0]   spd_q;
  logic [DUTY_W:0]           drv;
  logic [3:0]                quo_ext;

  assign add_y = add_a + (add_sub ? ~add_b : add_b) + {{(ACC_W-1){1'b0}}, add_sub};
  assign mul_y = mul_a * mul_b;

  assign delta   = 5'(err_r) - 5'(prior_r);
  assign base_sh = ACC_W'({base_r, {GAIN_FRAC_BITS{1'b0}}});
  assign spd_q   = add_y >>> GAIN_FRAC_BITS;
  assign drv     = drive_split(spd_q);
  assign quo_ext = {1'b0, quo_r};

  // Weighted sum in halves and active-sensor count
  always_comb begin
    sum2 = '0;
    cnt  = '0;
    for (int i = 0; i < BITS_W; i++) begin
      if (in_line_bits[i]) begin
        sum2 = sum2 + 6'(HALF_WEIGHT[i]);
        cnt  = cnt + 3'd1;
      end
    end
    sum2_abs = sum2[5] ? (~sum2 + 6'd1) : sum2;
  end

  assign in_stall = (state_r != S_IDLE);

  // Sequencer: next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r & out_stall;
    error_sum_nxt  = error_sum_r;
    prior_nxt      = prior_r;
    mag_nxt        = mag_r;
    cnt_nxt        = cnt_r;
    neg_nxt        = neg_r;
    quo_nxt        = quo_r;
    err_nxt        = err_r;
    prod_nxt       = prod_r;
    acc_nxt        = acc_r;
    spd_nxt        = spd_r;
    left_fwd_nxt   = left_fwd_r;
    left_duty_nxt  = left_duty_r;
    right_fwd_nxt  = right_fwd_r;
    right_duty_nxt = right_duty_r;
    out_err_nxt    = out_err_r;
    out_lfwd_nxt   = out_lfwd_r;
    out_lduty_nxt  = out_lduty_r;
    out_rfwd_nxt   = out_rfwd_r;
    out_rduty_nxt  = out_rduty_r;
    add_sub        = 1'b0;
    add_a          = '0;
    add_b          = '0;
    mul_a          = '0;
    mul_b          = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mag_nxt   = sum2_abs[4:1];
          neg_nxt   = sum2[5];
          cnt_nxt   = cnt;
          quo_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      // Repeated subtraction: one count off the magnitude per cycle
      S_DIV: begin
        add_a   = ACC_W'(mag_r);
        add_b   = ACC_W'(cnt_r);
        add_sub = 1'b1;
        if ((cnt_r != 3'd0) && !add_y[ACC_W-1]) begin
          mag_nxt = add_y[3:0];
          quo_nxt = quo_r + 3'd1;
        end else begin
          err_nxt   = neg_r ? (~quo_ext + 4'd1) : quo_ext;
          state_nxt = S_INTEG;
        end
      end
      // Saturating integral update; proportional product alongside
      S_INTEG: begin
        add_a = ACC_W'(error_sum_r);
        add_b = ACC_W'(err_r);
        if (add_y > SUM_HI) begin
          error_sum_nxt = SUM_HI[SUM_WIDTH-1:0];
        end else if (add_y < SUM_LO) begin
          error_sum_nxt = SUM_LO[SUM_WIDTH-1:0];
        end else begin
          error_sum_nxt = add_y[SUM_WIDTH-1:0];
        end
        mul_a     = {1'b0, prop_r};
        mul_b     = MUL_B_W'(err_r);
        prod_nxt  = mul_y;
        state_nxt = S_MUL_I;
      end
      S_MUL_I: begin
        acc_nxt   = ACC_W'(prod_r);
        mul_a     = {1'b0, integ_r};
        mul_b     = error_sum_r;
        prod_nxt  = mul_y;
        state_nxt = S_MUL_D;
      end
      S_MUL_D: begin
        add_a     = acc_r;
        add_b     = ACC_W'(prod_r);
        acc_nxt   = add_y;
        mul_a     = {1'b0, deriv_r};
        mul_b     = MUL_B_W'(delta);
        prod_nxt  = mul_y;
        prior_nxt = err_r;
        state_nxt = S_ACC_D;
      end
      S_ACC_D: begin
        add_a     = acc_r;
        add_b     = ACC_W'(prod_r);
        acc_nxt   = add_y;
        state_nxt = S_SPD_L;
      end
      S_SPD_L: begin
        add_a     = base_sh;
        add_b     = acc_r;
        spd_nxt   = add_y;
        state_nxt = S_RND_L;
      end
      S_RND_L: begin
        add_a         = spd_r;
        add_b         = spd_r[ACC_W-1] ? ROUND_BIAS : '0;
        left_fwd_nxt  = drv[DUTY_W];
        left_duty_nxt = drv[DUTY_W-1:0];
        state_nxt     = S_SPD_R;
      end
      S_SPD_R: begin
        add_a     = base_sh;
        add_b     = acc_r;
        add_sub   = 1'b1;
        spd_nxt   = add_y;
        state_nxt = S_RND_R;
      end
      S_RND_R: begin
        add_a          = spd_r;
        add_b          = spd_r[ACC_W-1] ? ROUND_BIAS : '0;
        right_fwd_nxt  = drv[DUTY_W];
        right_duty_nxt = drv[DUTY_W-1:0];
        state_nxt      = S_OUT;
      end
      // Hold until the output register is free, then load it
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_err_nxt   = err_r;
          out_lfwd_nxt  = left_fwd_r;
          out_lduty_nxt = left_duty_r;
          out_rfwd_nxt  = right_fwd_r;
          out_rduty_nxt = right_duty_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      error_sum_r <= '0;
      prior_r     <= '0;
      prop_r      <= PROP_GAIN_RST;
      integ_r     <= INTEG_GAIN_RST;
      deriv_r     <= DERIV_GAIN_RST;
      base_r      <= BASE_SPEED_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      error_sum_r <= error_sum_nxt;
      prior_r     <= prior_nxt;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_PROP_GAIN:  prop_r  <= cfg_data;
          REG_INTEG_GAIN: integ_r <= cfg_data;
          REG_DERIV_GAIN: deriv_r <= cfg_data;
          REG_BASE_SPEED: base_r  <= cfg_data[BASE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mag_r        <= mag_nxt;
    cnt_r        <= cnt_nxt;
    neg_r        <= neg_nxt;
    quo_r        <= quo_nxt;
    err_r        <= err_nxt;
    prod_r       <= prod_nxt;
    acc_r        <= acc_nxt;
    spd_r        <= spd_nxt;
    left_fwd_r   <= left_fwd_nxt;
    left_duty_r  <= left_duty_nxt;
    right_fwd_r  <= right_fwd_nxt;
    right_duty_r <= right_duty_nxt;
    out_err_r    <= out_err_nxt;
    out_lfwd_r   <= out_lfwd_nxt;
    out_lduty_r  <= out_lduty_nxt;
    out_rfwd_r   <= out_rfwd_nxt;
    out_rduty_r  <= out_rduty_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_line_error    = out_err_r;
  assign out_left_forward  = out_lfwd_r;
  assign out_left_duty     = out_lduty_r;
  assign out_right_forward = out_rfwd_r;
  assign out_right_duty    = out_rduty_r;

  // Divide leaves an error within the sensor span
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INTEG) |-> ((err_r >= -4'sd4) && (err_r <= 4'sd4)))
    else $error("line error out of range after divide");

  // An accepted beat starts the divide
  a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DIV))
    else $error("accepted beat did not start the divide");

  // A finished result waits while the output register is still held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_OUT) && out_valid_r && out_stall) |=> (state_r == S_OUT))
    else $error("finished result dropped behind a stalled output");

  // Limited duties never exceed full scale
  a_duty_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_lduty_r <= DUTY_W'(SPEED_MAX)) &&
                     (out_rduty_r <= DUTY_W'(SPEED_MAX))))
    else $error("duty above full scale");

  // Forward implies a nonzero duty
  a_fwd_duty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_lfwd_r || out_rfwd_r)) |->
      ((!out_lfwd_r || (out_lduty_r != '0)) && (!out_rfwd_r || (out_rduty_r != '0))))
    else $error("forward direction with zero duty");

endmodule

`default_nettype wire

// ----- bench/line_follow_pid_motor_drive_tb.sv -----
// ----------------------------------------------------------------------------
// line_follow_pid_motor_drive_tb: self-checking bench for the steering block
// Drives sensor beats, predicts line error and motor drive per beat, and
// checks every steering beat against a queue of predictions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_follow_pid_motor_drive_tb
  import lfpmd_pkg::*;
();

  // Cycles with no beat moving on either channel before the run is abandoned.
  // Worst legal quiet stretch is the long receiver hold (HOLD_CYCLES) plus one item.
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int STEADY_LEFT_ITEMS = 30;
  localparam int STEADY_RIGHT_ITEMS = 30;
  localparam int SEG_ITEMS = 40;
  localparam int MAX_REPORTS = 30;

  typedef struct packed {
    logic signed [ERR_W-1:0] line_error;
    logic                    left_forward;
    logic [DUTY_W-1:0]       left_duty;
    logic                    right_forward;
    logic [DUTY_W-1:0]       right_duty;
  } steering_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [BITS_W-1:0] in_line_bits = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ERR_W-1:0] out_line_error;
  logic out_left_forward;
  logic [DUTY_W-1:0] out_left_duty;
  logic out_right_forward;
  logic [DUTY_W-1:0] out_right_duty;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Predictor copy of the registers and the PID state
  logic [GAIN_W-1:0] kp_model = 18'd84480;
  logic [GAIN_W-1:0] ki_model = 18'd13;
  logic [GAIN_W-1:0] kd_model = 18'd0;
  logic [BASE_W-1:0] base_model = 10'd430;
  longint integ_acc = 0;
  int prev_err_model = 0;

  steering_t expected_steering[$];
  int mismatches = 0;
  int quiet_cycles = 0;

  // Idling controls, owned by the tests
  bit sender_idle = 1'b0;
  bit receiver_idle = 1'b0;
  int hold_request = 0;

  line_follow_pid_motor_drive i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_line_bits     (in_line_bits),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_line_error   (out_line_error),
    .out_left_forward (out_left_forward),
    .out_left_duty    (out_left_duty),
    .out_right_forward(out_right_forward),
    .out_right_duty   (out_right_duty),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Steering prediction for one sensor beat; advances the integral and the
  // remembered error exactly as the block must.
  function automatic steering_t predict_steering(input logic [BITS_W-1:0] bits);
    steering_t res;
    int half_sum;
    int active;
    int err;
    int w;
    longint pid;
    longint base_q;
    longint spd [2];
    longint lim;
    half_sum = 0;
    active = 0;
    for (int i = 0; i < BITS_W; i++) begin
      case (i)
        0: w = -8;
        1: w = -5;
        2: w = -3;
        3: w = 3;
        4: w = 5;
        default: w = 8;
      endcase
      if (bits[i]) begin
        half_sum += w;
        active++;
      end
    end
    // SV integer division truncates toward zero, as the block must
    err = (active == 0) ? 0 : (half_sum / 2) / active;

    // Saturate the integral at the signed 16-bit bounds
    integ_acc = integ_acc + err;
    if (integ_acc > 32767) integ_acc = 32767;
    if (integ_acc < -32768) integ_acc = -32768;

    pid = longint'(kp_model) * err + longint'(ki_model) * integ_acc
          + longint'(kd_model) * (err - prev_err_model);
    prev_err_model = err;
    base_q = longint'(base_model) * (longint'(1) << GAIN_FRAC_BITS);
    spd[0] = (base_q + pid) / (longint'(1) << GAIN_FRAC_BITS);
    spd[1] = (base_q - pid) / (longint'(1) << GAIN_FRAC_BITS);

    res.line_error = err[ERR_W-1:0];
    for (int s = 0; s < 2; s++) begin
      // Above 999 drops to 950; 951..999 pass; below -950 clips to -950
      lim = spd[s];
      if (lim > 999) lim = 950;
      if (lim < -950) lim = -950;
      if (s == 0) begin
        res.left_forward = (lim > 0);
        res.left_duty = (lim < 0) ? DUTY_W'(-lim) : DUTY_W'(lim);
      end else begin
        res.right_forward = (lim > 0);
        res.right_duty = (lim < 0) ? DUTY_W'(-lim) : DUTY_W'(lim);
      end
    end
    return res;
  endfunction

  // Offer one sensor beat, hold it until accepted, queue its prediction.
  task automatic send_line_bits(input logic [BITS_W-1:0] bits);
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      in_line_bits <= BITS_W'($urandom);
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_line_bits <= bits;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_steering.push_back(predict_steering(bits));
  endtask

  // Drop valid and wait until every predicted beat has come back, then let
  // the datapath settle for a few cycles.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (expected_steering.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers back to back; only call with the block idle.
  // Data bits above the base speed field are ignored by the block and may carry junk.
  task automatic load_registers(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                                input logic [GAIN_W-1:0] kd, input logic [CFG_W-1:0] base_word);
    cfg_we <= 1'b1;
    cfg_index <= REG_PROP_GAIN;
    cfg_data <= kp;
    @(posedge clk);
    cfg_index <= REG_INTEG_GAIN;
    cfg_data <= ki;
    @(posedge clk);
    cfg_index <= REG_DERIV_GAIN;
    cfg_data <= kd;
    @(posedge clk);
    cfg_index <= REG_BASE_SPEED;
    cfg_data <= base_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    kp_model = kp;
    ki_model = ki;
    kd_model = kd;
    base_model = base_word[BASE_W-1:0];
  endtask

  // Receiver: check each accepted steering beat, then pick next stall value.
  // A long hold request from a test takes priority over random bursts.
  always @(posedge clk) begin : steering_check
    steering_t got;
    steering_t want;
    int hold_left;
    int burst_left;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      got = '{out_line_error, out_left_forward, out_left_duty,
              out_right_forward, out_right_duty};
      if (expected_steering.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: steering beat with nothing expected: err %0d L %0b/%0d R %0b/%0d",
                   $time, got.line_error, got.left_forward, got.left_duty,
                   got.right_forward, got.right_duty);
      end else begin
        want = expected_steering.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display(
              "%0t: mismatch: exp err %0d L %0b/%0d R %0b/%0d, got err %0d L %0b/%0d R %0b/%0d",
              $time, want.line_error, want.left_forward, want.left_duty,
              want.right_forward, want.right_duty,
              got.line_error, got.left_forward, got.left_duty,
              got.right_forward, got.right_duty);
        end
      end
    end
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (receiver_idle && $urandom_range(0, 4) == 0) begin
      burst_left = $urandom_range(1, 11) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: abandon the run if no beat moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("line_follow_pid_motor_drive regression: fail");
      $finish;
    end
  end

  // Reset-value registers: extremes of the sensor field, every single sensor,
  // and pairs and wider groups that exercise both truncation steps.
  task automatic test_sensor_patterns();
    logic [BITS_W-1:0] pats [20] = '{
      6'h00, 6'h3F, 6'h01, 6'h02, 6'h04, 6'h08, 6'h10, 6'h20, 6'h03, 6'h06,
      6'h07, 6'h0C, 6'h30, 6'h18, 6'h38, 6'h1E, 6'h21, 6'h15, 6'h2A, 6'h00
    };
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
    foreach (pats[i]) send_line_bits(pats[i]);
    drain_pipeline();
  endtask

  // Speed limiter corners: pass band 951..999, base above 999, zero speed,
  // and full clip in both directions.
  task automatic test_speed_limits();
    load_registers(18'd0, 18'd0, 18'd0, 18'd975);
    send_line_bits(6'h00);
    send_line_bits(6'h0C);
    drain_pipeline();
    load_registers(18'd0, 18'd0, 18'd0, 18'd1023);
    send_line_bits(6'h00);
    drain_pipeline();
    load_registers(18'd0, 18'd0, 18'd0, 18'h3FC00);
    send_line_bits(6'h00);
    send_line_bits(6'h00);
    drain_pipeline();
    load_registers(18'h3FFFF, 18'd0, 18'h3FFFF, 18'd0);
    send_line_bits(6'h01);
    send_line_bits(6'h20);
    send_line_bits(6'h00);
    drain_pipeline();
    load_registers(18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF);
    send_line_bits(6'h20);
    send_line_bits(6'h01);
    drain_pipeline();
  endtask

  // Random traffic in segments, each with its own register setting.
  // Most beats look like a real line under the sensors: a short run of
  // adjacent active bits; the rest are empty or arbitrary patterns.
  task automatic test_random_traffic();
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [CFG_W-1:0] base_word;
    logic [BITS_W-1:0] bits;
    int run_w;
    int pick;
    for (int seg = 0; seg < 12; seg++) begin
      if (seg == 0) begin
        kp = '1; ki = '1; kd = '1; base_word = '1;
      end else if (seg == 1) begin
        kp = '0; ki = '0; kd = '0; base_word = '0;
      end else begin
        kp = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom) : GAIN_W'($urandom_range(0, 4096));
        ki = ($urandom_range(0, 4) == 0) ? GAIN_W'($urandom) : GAIN_W'($urandom_range(0, 64));
        kd = ($urandom_range(0, 4) == 0) ? GAIN_W'($urandom) : GAIN_W'($urandom_range(0, 4096));
        base_word = {(CFG_W-BASE_W)'($urandom), BASE_W'($urandom_range(0, 1023))};
      end
      load_registers(kp, ki, kd, base_word);
      // Every fourth segment runs with no idling on either side
      sender_idle = (seg % 4 != 3);
      receiver_idle = (seg % 4 != 3);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          run_w = $urandom_range(1, 3);
          bits = BITS_W'(((1 << run_w) - 1) << $urandom_range(0, BITS_W - run_w));
        end else if (pick == 7) begin
          bits = '0;
        end else begin
          bits = BITS_W'($urandom);
        end
        send_line_bits(bits);
      end
      drain_pipeline();
    end
  endtask

  // Hold the receiver off for a long stretch while beats keep coming, so the
  // output register fills and the block stalls its input.
  task automatic test_output_backpressure();
    load_registers(18'd84480, 18'd13, 18'd512, 18'd430);
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    hold_request = HOLD_CYCLES;
    for (int n = 0; n < 12; n++) send_line_bits(BITS_W'($urandom));
    drain_pipeline();
  endtask

  // Wind the integral down with a steady full-left line, then back up with
  // a steady full-right line. No idling from here on.
  task automatic test_integral_steady();
    load_registers(18'd256, 18'd1, 18'd0, 18'd430);
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    for (int n = 0; n < STEADY_LEFT_ITEMS; n++) send_line_bits(6'h01);
    for (int n = 0; n < STEADY_RIGHT_ITEMS; n++) send_line_bits(6'h20);
    drain_pipeline();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_sensor_patterns();
    test_speed_limits();
    test_random_traffic();
    test_output_backpressure();
    test_integral_steady();

    // Everything has drained; give any stray beat a chance to show up
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_steering.size() == 0) begin
      $display("line_follow_pid_motor_drive regression: pass");
    end else begin
      $display("line_follow_pid_motor_drive regression: fail");
    end
    $finish;
  end

endmodule

// ----- line_follow_pid_motor_drive.f -----
src/lfpmd_pkg.sv
src/line_follow_pid_motor_drive.sv
bench/line_follow_pid_motor_drive_tb.sv
